// File: design/rhsv_pkg.sv
// Shared types, constants and the restoring-division step for the RGB to HSV block.
// Used by rhsv_front, rhsv_queue, rhsv_back and rgb_to_hsv_converter.
package rhsv_pkg;

    localparam int CHAN_W     = 8;
    localparam int HUE_W      = 9;
    localparam int NUM_W      = 2 * CHAN_W;
    localparam int DIV_STEPS  = CHAN_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int S_DATA_W   = 3 * CHAN_W;
    localparam int M_DATA_W   = 32;

    localparam logic [HUE_W-1:0] HUE_GREEN = 9'd120;
    localparam logic [HUE_W-1:0] HUE_BLUE  = 9'd240;
    localparam logic [HUE_W-1:0] HUE_FULL  = 9'd360;

    // Which channel holds the maximum
    localparam logic [1:0] SEL_RED   = 2'd0;
    localparam logic [1:0] SEL_GREEN = 2'd1;
    localparam logic [1:0] SEL_BLUE  = 2'd2;

    // Partial remainder plus a word that shifts out numerator bits and shifts in quotient bits
    typedef struct packed {
        logic [CHAN_W-1:0] rem;
        logic [CHAN_W-1:0] work;
    } div_t;

    typedef struct packed {
        div_t              sat_div;
        div_t              hue_div;
        logic [CHAN_W-1:0] vmax;
        logic [CHAN_W-1:0] delta;
        logic              grey;
        logic              neg;
        logic [1:0]        sel;
    } item_t;

    function automatic div_t div_step(input div_t x, input logic [CHAN_W-1:0] d);
        logic [CHAN_W:0] t;
        logic            q;
        div_t            y;
        t = {x.rem, x.work[CHAN_W-1]};
        q = (t >= {1'b0, d});
        if (q)
        begin
            y.rem = CHAN_W'(t - {1'b0, d});
        end
        else
        begin
            y.rem = t[CHAN_W-1:0];
        end
        y.work = {x.work[CHAN_W-2:0], q};
        return y;
    endfunction

    function automatic item_t item_step(input item_t x);
        item_t y;
        y = x;
        y.sat_div = div_step(x.sat_div, x.vmax);
        y.hue_div = div_step(x.hue_div, x.delta);
        return y;
    endfunction

endpackage

// File: design/rhsv_front.sv
// Front end: accepts pixels, finds max/min/delta, picks the hue sector and
// sets up both dividends. Depends on rhsv_pkg.
module rhsv_front
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [rhsv_pkg::S_DATA_W-1:0]    in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output rhsv_pkg::item_t                  out_item
);

    logic [rhsv_pkg::CHAN_W-1:0] r;
    logic [rhsv_pkg::CHAN_W-1:0] g;
    logic [rhsv_pkg::CHAN_W-1:0] b;
    logic [rhsv_pkg::CHAN_W-1:0] mx;
    logic [rhsv_pkg::CHAN_W-1:0] mn;
    logic [rhsv_pkg::CHAN_W-1:0] delta;
    logic [rhsv_pkg::CHAN_W-1:0] da;
    logic [rhsv_pkg::CHAN_W-1:0] db;
    logic [rhsv_pkg::CHAN_W-1:0] mag;
    logic [rhsv_pkg::NUM_W-1:0]  sat_num;
    logic [rhsv_pkg::NUM_W-1:0]  hue_num;
    logic [1:0]                  sel;
    logic                        neg;
    logic                        valid_reg;
    logic                        valid_next;
    rhsv_pkg::item_t             item_reg;
    rhsv_pkg::item_t             item_next;

    assign r = in_data[rhsv_pkg::CHAN_W-1:0];
    assign g = in_data[2*rhsv_pkg::CHAN_W-1:rhsv_pkg::CHAN_W];
    assign b = in_data[3*rhsv_pkg::CHAN_W-1:2*rhsv_pkg::CHAN_W];

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        // Red wins ties, then green
        priority if (r >= g && r >= b)
        begin
            sel = rhsv_pkg::SEL_RED;
            mx  = r;
            da  = g;
            db  = b;
        end
        else if (g >= b)
        begin
            sel = rhsv_pkg::SEL_GREEN;
            mx  = g;
            da  = b;
            db  = r;
        end
        else
        begin
            sel = rhsv_pkg::SEL_BLUE;
            mx  = b;
            da  = r;
            db  = g;
        end

        mn = r;
        if (g < mn)
        begin
            mn = g;
        end
        if (b < mn)
        begin
            mn = b;
        end
        delta = mx - mn;

        neg = (da < db);
        mag = neg ? (db - da) : (da - db);

        // delta*255 and |diff|*60 by shift and subtract
        sat_num = {delta, 8'd0} - {8'd0, delta};
        hue_num = {2'd0, mag, 6'd0} - {6'd0, mag, 2'd0};

        item_next.sat_div.rem  = sat_num[rhsv_pkg::NUM_W-1:rhsv_pkg::CHAN_W];
        item_next.sat_div.work = sat_num[rhsv_pkg::CHAN_W-1:0];
        item_next.hue_div.rem  = hue_num[rhsv_pkg::NUM_W-1:rhsv_pkg::CHAN_W];
        item_next.hue_div.work = hue_num[rhsv_pkg::CHAN_W-1:0];
        item_next.vmax  = mx;
        item_next.delta = delta;
        item_next.grey  = (delta == '0);
        item_next.neg   = neg;
        item_next.sel   = sel;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// File: design/rhsv_queue.sv
// Short FIFO of classified items between front and back end.
// Depends on rhsv_pkg; DEPTH must be a power of two, at least 2.
module rhsv_queue
#(
    parameter int DEPTH = rhsv_pkg::QUEUE_DEPTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  rhsv_pkg::item_t wr_item,
    output logic            rd_valid,
    input  logic            rd_ready,
    output rhsv_pkg::item_t rd_item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    rhsv_pkg::item_t    mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               wr_en;
    logic               rd_en;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_valid && rd_ready;
    assign rd_item  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// File: design/rhsv_back.sv
// Back end: two restoring dividers, one quotient bit per stage, then the
// hue offset and wrap into an output register. Depends on rhsv_pkg.
module rhsv_back
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  rhsv_pkg::item_t                     in_item,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [rhsv_pkg::HUE_W-1:0]          hue,
    output logic [rhsv_pkg::CHAN_W-1:0]         saturation,
    output logic [rhsv_pkg::CHAN_W-1:0]         brightness_value
);

    localparam int STAGES = rhsv_pkg::DIV_STEPS;

    rhsv_pkg::item_t             stage_reg  [STAGES];
    rhsv_pkg::item_t             stage_next [STAGES];
    logic [STAGES-1:0]           valid_reg;
    logic [STAGES-1:0]           valid_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [rhsv_pkg::HUE_W-1:0]  hue_reg;
    logic [rhsv_pkg::HUE_W-1:0]  hue_next;
    logic [rhsv_pkg::CHAN_W-1:0] sat_reg;
    logic [rhsv_pkg::CHAN_W-1:0] sat_next;
    logic [rhsv_pkg::CHAN_W-1:0] val_reg;
    logic                        adv;
    rhsv_pkg::item_t             last;
    logic [rhsv_pkg::HUE_W-1:0]  q;

    // Whole pipeline advances unless the output item is stuck
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;
    assign last     = stage_reg[STAGES-1];

    always_comb
    begin
        stage_next[0] = rhsv_pkg::item_step(in_item);
        valid_next[0] = in_valid;
        for (int k = 1; k < STAGES; k++)
        begin
            stage_next[k] = rhsv_pkg::item_step(stage_reg[k-1]);
            valid_next[k] = valid_reg[k-1];
        end
    end

    always_comb
    begin
        q = {1'b0, last.hue_div.work};
        unique case (last.sel)
            rhsv_pkg::SEL_RED:
            begin
                if (!last.neg)
                begin
                    hue_next = q;
                end
                else if (q == '0)
                begin
                    hue_next = '0;
                end
                else
                begin
                    hue_next = rhsv_pkg::HUE_FULL - q;
                end
            end
            rhsv_pkg::SEL_GREEN:
            begin
                hue_next = last.neg ? rhsv_pkg::HUE_GREEN - q : rhsv_pkg::HUE_GREEN + q;
            end
            default:
            begin
                hue_next = last.neg ? rhsv_pkg::HUE_BLUE - q : rhsv_pkg::HUE_BLUE + q;
            end
        endcase
        sat_next = last.sat_div.work;
        // Grey or black pixel
        if (last.grey)
        begin
            hue_next = '0;
            sat_next = '0;
        end
        out_valid_next = adv ? valid_reg[STAGES-1] : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                valid_reg <= valid_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                stage_reg[k] <= stage_next[k];
            end
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            val_reg <= last.vmax;
        end
    end

    assign out_valid        = out_valid_reg;
    assign hue              = hue_reg;
    assign saturation       = sat_reg;
    assign brightness_value = val_reg;

endmodule

// File: design/rgb_to_hsv_converter.sv
// RGB to integer HSV converter, top level. Uses rhsv_pkg, rhsv_front, rhsv_queue, rhsv_back.
// A pixel passes the front register, the queue, the divider stages and the output register.
// Throughput: one item per cycle unless stalled; bit-per-stage divider pipeline (8 stages).
// The queue between front and back end holds QUEUE_DEPTH items so either side can stall.
// Reset (rst_n low, asynchronous) clears all valid flags; payload registers are not reset.
module rgb_to_hsv_converter
#(
    parameter int QUEUE_DEPTH = rhsv_pkg::QUEUE_DEPTH
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rhsv_pkg::S_DATA_W-1:0]  s_tdata,   // red[7:0], green[15:8], blue[23:16]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rhsv_pkg::M_DATA_W-1:0]  m_tdata    // hue[8:0], saturation[16:9],
                                                      // brightness_value[24:17], zero[31:25]
);

    rhsv_pkg::item_t             f_item;
    rhsv_pkg::item_t             q_item;
    logic                        f_valid;
    logic                        f_ready;
    logic                        q_valid;
    logic                        q_ready;
    logic [rhsv_pkg::HUE_W-1:0]  hue;
    logic [rhsv_pkg::CHAN_W-1:0] saturation;
    logic [rhsv_pkg::CHAN_W-1:0] brightness_value;

    rhsv_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_item  (f_item)
    );

    rhsv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_item  (f_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_item  (q_item)
    );

    rhsv_back u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (q_valid),
        .in_ready         (q_ready),
        .in_item          (q_item),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .hue              (hue),
        .saturation       (saturation),
        .brightness_value (brightness_value)
    );

    assign m_tdata = {7'd0, brightness_value, saturation, hue};

endmodule

// File: bench/tb_top.sv
// Self-checking bench for rgb_to_hsv_converter: sends pixels, predicts each HSV result
// from its own integer model and compares in order. Depends on rhsv_pkg and the RTL.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HUE_OFS_GREEN = 120;
    localparam int HUE_OFS_BLUE  = 240;
    localparam int HUE_CIRCLE    = 360;
    localparam int HUE_SECTOR    = 60;
    localparam int SAT_SCALE     = 255;
    localparam int DRAIN_CYCLES  = 20;
    localparam int DRAIN_LIMIT   = 2000;

    typedef struct packed {
        logic [6:0]                    pad;
        logic [rhsv_pkg::CHAN_W-1:0]   value;
        logic [rhsv_pkg::CHAN_W-1:0]   sat;
        logic [rhsv_pkg::HUE_W-1:0]    hue;
    } hsv_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [rhsv_pkg::S_DATA_W-1:0]   s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [rhsv_pkg::M_DATA_W-1:0]   m_tdata;

    hsv_t expected_hsv[$];
    int   mismatch_count = 0;
    int   rx_hold_left = 0;
    bit   no_gaps = 1'b0;

    rgb_to_hsv_converter u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic hsv_t predict_hsv(input logic [rhsv_pkg::S_DATA_W-1:0] pixel);
        int   r;
        int   g;
        int   b;
        int   vmax;
        int   vmin;
        int   delta;
        int   h;
        int   s;
        hsv_t res;
        r = int'(pixel[7:0]);
        g = int'(pixel[15:8]);
        b = int'(pixel[23:16]);
        vmax = r;
        vmin = r;
        if (g > vmax) vmax = g;
        if (b > vmax) vmax = b;
        if (g < vmin) vmin = g;
        if (b < vmin) vmin = b;
        delta = vmax - vmin;
        h = 0;
        s = 0;
        if (vmax != 0 && delta != 0)
        begin
            s = (delta * SAT_SCALE) / vmax;
            // ties go to red first, then green
            if (r == vmax)
                h = ((g - b) * HUE_SECTOR) / delta;
            else if (g == vmax)
                h = ((b - r) * HUE_SECTOR) / delta + HUE_OFS_GREEN;
            else
                h = ((r - g) * HUE_SECTOR) / delta + HUE_OFS_BLUE;
            if (h < 0) h += HUE_CIRCLE;
            h = h % HUE_CIRCLE;
        end
        res.pad   = '0;
        res.hue   = h[rhsv_pkg::HUE_W-1:0];
        res.sat   = s[rhsv_pkg::CHAN_W-1:0];
        res.value = vmax[rhsv_pkg::CHAN_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Predict on every accepted pixel
    always @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            expected_hsv.push_back(predict_hsv(s_tdata));
    end

    // Compare every accepted result with the oldest prediction
    always @(posedge clk)
    begin
        hsv_t got;
        hsv_t exp_res;
        if (m_tvalid && m_tready)
        begin
            got = hsv_t'(m_tdata);
            if (expected_hsv.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %h", m_tdata));
            end
            else
            begin
                exp_res = expected_hsv.pop_front();
                if (got.hue !== exp_res.hue)
                    report_mismatch($sformatf("hue got %0d exp %0d", got.hue, exp_res.hue));
                if (got.sat !== exp_res.sat)
                    report_mismatch($sformatf("saturation got %0d exp %0d",
                                              got.sat, exp_res.sat));
                if (got.value !== exp_res.value)
                    report_mismatch($sformatf("value got %0d exp %0d",
                                              got.value, exp_res.value));
                if (got.pad !== exp_res.pad)
                    report_mismatch($sformatf("upper bits got %h exp 0", got.pad));
            end
        end
    end

    // Result side: random stalls, or a counted hold-off when requested
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rx_hold_left > 0)
            begin
                m_tready <= 1'b0;
                rx_hold_left--;
            end
            else
            begin
                m_tready <= no_gaps || ($urandom_range(99) >= 10);
            end
        end
    end

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        @(negedge clk);
        while (!no_gaps && $urandom_range(99) < 10)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, g, r};
        // hold the item until it is taken
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic stop_sending();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic test_directed();
        send_pixel(8'd0,   8'd0,   8'd0);    // black
        send_pixel(8'd255, 8'd255, 8'd255);  // white
        send_pixel(8'd128, 8'd128, 8'd128);  // grey
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);    // red and green tie
        send_pixel(8'd0,   8'd255, 8'd255);  // green and blue tie
        send_pixel(8'd255, 8'd0,   8'd255);  // red and blue tie
        send_pixel(8'd255, 8'd0,   8'd1);    // negative quotient truncates to zero
        send_pixel(8'd255, 8'd0,   8'd128);  // negative red hue wraps
        send_pixel(8'd200, 8'd100, 8'd0);
        send_pixel(8'd50,  8'd200, 8'd10);
        send_pixel(8'd10,  8'd50,  8'd200);
        send_pixel(8'd200, 8'd10,  8'd180);
        send_pixel(8'd1,   8'd0,   8'd0);    // smallest nonzero delta
        send_pixel(8'd0,   8'd1,   8'd0);
        send_pixel(8'd0,   8'd0,   8'd1);
        send_pixel(8'd255, 8'd254, 8'd254);
        send_pixel(8'd254, 8'd255, 8'd253);
        send_pixel(8'd170, 8'd85,  8'd255);
        stop_sending();
    endtask

    task automatic test_random(input int count);
        logic [7:0] c[3];
        int         base;
        int         k;
        for (int i = 0; i < count; i++)
        begin
            k = $urandom_range(9);
            base = $urandom_range(255);
            for (int j = 0; j < 3; j++)
            begin
                if (k < 6)
                    c[j] = 8'($urandom_range(255));
                else if (k < 8)
                    c[j] = 8'(base + $urandom_range(3) < 256 ? base + $urandom_range(3) : base);
                else
                    c[j] = ($urandom_range(2) == 0) ? 8'($urandom_range(255))
                                                     : (($urandom_range(1) == 0) ? 8'd0 : 8'd255);
            end
            send_pixel(c[0], c[1], c[2]);
        end
        stop_sending();
    endtask

    task automatic test_streaming(input int count);
        no_gaps = 1'b1;
        for (int i = 0; i < count; i++)
            send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
        stop_sending();
        no_gaps = 1'b0;
    endtask

    task automatic test_backpressure(input int count);
        no_gaps = 1'b1;
        rx_hold_left = 100;
        // keep offering while the result side is held off, so the input stalls
        for (int i = 0; i < count; i++)
            send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
        stop_sending();
        no_gaps = 1'b0;
    endtask

    initial
    begin
        int waited;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        test_directed();
        test_random(1700);
        test_streaming(200);
        test_backpressure(60);
        test_random(100);

        waited = 0;
        while (expected_hsv.size() > 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_hsv.size() > 0)
            report_mismatch($sformatf("%0d results never arrived", expected_hsv.size()));

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("TIMEOUT");
        $display("Regression FAIL");
        $finish;
    end

endmodule

// File: filelist.f
design/rhsv_pkg.sv
design/rhsv_front.sv
design/rhsv_queue.sv
design/rhsv_back.sv
design/rgb_to_hsv_converter.sv
bench/tb_top.sv
